/* rtl/shd_pkg.sv */
// Package for the stick heading block: widths, constants, CORDIC table and helpers.
`timescale 1ns / 1ps
package shd_pkg;

  localparam int ANGLE_FRAC_BITS = 6;
  localparam int ACC_FRAC        = 24;
  localparam int STEPS           = 28;
  localparam int VEC_SHIFT       = 30;
  localparam int VEC_W           = 40;
  localparam int ACC_W           = 34;
  localparam int HEAD_W          = 15;
  localparam int DZ_W            = 7;
  localparam int AXIS_W          = 9;

  localparam logic [DZ_W-1:0] DEADZONE_RST = 7'd48;

  localparam logic signed [AXIS_W-1:0] AXIS_MAX = 9'sd128;
  localparam logic signed [AXIS_W-1:0] AXIS_MIN = -9'sd128;
  localparam logic signed [AXIS_W-1:0] AXIS_CTR = 9'sd128;

  localparam logic signed [ACC_W-1:0] QUARTER = 34'sd1509949440;

  // dpad bit positions
  localparam int DPAD_UP    = 0;
  localparam int DPAD_RIGHT = 1;
  localparam int DPAD_DOWN  = 2;
  localparam int DPAD_LEFT  = 3;

  typedef struct packed {
    logic signed [VEC_W-1:0] cx;
    logic signed [VEC_W-1:0] cy;
    logic signed [ACC_W-1:0] acc;
    logic                    moved;
  } cordic_t;

  // atan(2^-i) in 2^-24 degree units
  function automatic logic signed [ACC_W-1:0] atan_deg(input int i);
    logic signed [ACC_W-1:0] r;
    case (i)
      0:  r = 34'sd754974720;
      1:  r = 34'sd445687602;
      2:  r = 34'sd235489088;
      3:  r = 34'sd119537938;
      4:  r = 34'sd60000934;
      5:  r = 34'sd30029717;
      6:  r = 34'sd15018523;
      7:  r = 34'sd7509720;
      8:  r = 34'sd3754917;
      9:  r = 34'sd1877466;
      10: r = 34'sd938734;
      11: r = 34'sd469367;
      12: r = 34'sd234684;
      13: r = 34'sd117342;
      14: r = 34'sd58671;
      15: r = 34'sd29335;
      16: r = 34'sd14668;
      17: r = 34'sd7334;
      18: r = 34'sd3667;
      19: r = 34'sd1833;
      20: r = 34'sd917;
      21: r = 34'sd458;
      22: r = 34'sd229;
      23: r = 34'sd115;
      24: r = 34'sd57;
      25: r = 34'sd29;
      26: r = 34'sd14;
      27: r = 34'sd7;
      default: r = '0;
    endcase
    return r;
  endfunction

  // arithmetic shift right, rounding toward zero
  function automatic logic signed [VEC_W-1:0] shr_tz(input logic signed [VEC_W-1:0] v,
                                                     input int s);
    logic [VEC_W-1:0] mag;
    logic [VEC_W-1:0] sh;
    mag = v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
    sh  = mag >> s;
    return v[VEC_W-1] ? -$signed(sh) : $signed(sh);
  endfunction

  function automatic logic in_band(input logic signed [AXIS_W-1:0] a,
                                   input logic [DZ_W-1:0] dz);
    logic [AXIS_W-1:0] mag;
    mag = a[AXIS_W-1] ? AXIS_W'(-a) : AXIS_W'(a);
    return mag <= {{(AXIS_W-DZ_W){1'b0}}, dz};
  endfunction

endpackage

/* rtl/shd_if.sv */
// Valid/ready channel interfaces for stick samples and heading words.
`timescale 1ns / 1ps
interface shd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stick_x;
  logic [7:0] stick_y;
  logic [3:0] dpad;
  logic       use_dpad;

  modport source (output valid, stick_x, stick_y, dpad, use_dpad, input ready);
  modport sink   (input valid, stick_x, stick_y, dpad, use_dpad, output ready);
endinterface

interface shd_out_if;
  logic                        valid;
  logic                        ready;
  logic [shd_pkg::HEAD_W-1:0]  heading;
  logic                        moved;

  modport source (output valid, heading, moved, input ready);
  modport sink   (input valid, heading, moved, output ready);
endinterface

/* rtl/stick_heading_with_deadzone.sv */
// Top level: deadzone register, front stage, CORDIC cell chain and output stage.
// Turns each stick sample (two raw bytes, D-pad bits, mode bit) into a heading word
// in 1/2^ANGLE_FRAC_BITS degree units plus a moved flag. The datapath is a front
// stage, a row of 28 CORDIC rotation cells and a rounding stage with the output
// register. It sustains one sample per cycle unless the output is back-pressured;
// every stage holds its own word so bubbles close up under back-pressure. The user must
// write the deadzone register (reset 48) via cfg_we_i/cfg_wdata_i only while idle; the block does not enforce it.
`timescale 1ns / 1ps
module stick_heading_with_deadzone #(
  parameter int ANGLE_FRAC_BITS = shd_pkg::ANGLE_FRAC_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [shd_pkg::DZ_W-1:0] cfg_wdata_i,
  shd_in_if.sink                   in_i,
  shd_out_if.source                out_o
);

  localparam int N = shd_pkg::STEPS;

  logic [shd_pkg::DZ_W-1:0] deadzone_q;
  logic                     valid_s [N+1];
  logic                     ready_s [N+1];
  shd_pkg::cordic_t         data_s  [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q <= shd_pkg::DEADZONE_RST;
    end else if (cfg_we_i) begin
      deadzone_q <= cfg_wdata_i;
    end
  end

  shd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .deadzone_i (deadzone_q),
    .in_i       (in_i),
    .valid_o    (valid_s[0]),
    .data_o     (data_s[0]),
    .ready_i    (ready_s[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    shd_cell #(
      .STEP (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[i]),
      .data_i  (data_s[i]),
      .ready_o (ready_s[i]),
      .valid_o (valid_s[i+1]),
      .data_o  (data_s[i+1]),
      .ready_i (ready_s[i+1])
    );
  end

  shd_round #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_s[N]),
    .data_i  (data_s[N]),
    .ready_o (ready_s[N]),
    .out_o   (out_o)
  );

endmodule

/* rtl/shd_front.sv */
// Front stage: centering, D-pad override, dead band and CORDIC pre-rotation.
`timescale 1ns / 1ps
module shd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [shd_pkg::DZ_W-1:0]    deadzone_i,
  shd_in_if.sink                      in_i,
  output logic                        valid_o,
  output shd_pkg::cordic_t            data_o,
  input  logic                        ready_i
);

  localparam int AW = shd_pkg::AXIS_W;

  logic                 valid_q;
  shd_pkg::cordic_t     data_q, data_d;
  logic signed [AW-1:0] x0, v0, x1, v1;
  logic signed [AW:0]   cx_s, cy_s;
  logic                 moved;

  assign in_i.ready = !valid_q || ready_i;

  always_comb begin
    x0 = $signed({1'b0, in_i.stick_x}) - shd_pkg::AXIS_CTR;
    v0 = $signed({1'b0, in_i.stick_y}) - shd_pkg::AXIS_CTR;
    v1 = v0;
    x1 = x0;
    if (in_i.use_dpad) begin
      if (in_i.dpad[shd_pkg::DPAD_UP]) begin
        v1 = shd_pkg::AXIS_MIN;
      end else if (in_i.dpad[shd_pkg::DPAD_DOWN]) begin
        v1 = shd_pkg::AXIS_MAX;
      end
      if ((in_i.dpad[shd_pkg::DPAD_LEFT] || in_i.dpad[shd_pkg::DPAD_RIGHT]) &&
          shd_pkg::in_band(v1, deadzone_i)) begin
        v1 = '0;
      end
      if (in_i.dpad[shd_pkg::DPAD_LEFT]) begin
        x1 = shd_pkg::AXIS_MIN;
      end else if (in_i.dpad[shd_pkg::DPAD_RIGHT]) begin
        x1 = shd_pkg::AXIS_MAX;
      end
      if ((in_i.dpad[shd_pkg::DPAD_UP] || in_i.dpad[shd_pkg::DPAD_DOWN]) &&
          shd_pkg::in_band(x1, deadzone_i)) begin
        x1 = '0;
      end
    end else begin
      if (shd_pkg::in_band(v0, deadzone_i)) begin
        v1 = '0;
      end
      if (shd_pkg::in_band(x0, deadzone_i)) begin
        x1 = '0;
      end
    end
    moved = !(shd_pkg::in_band(v1, deadzone_i) && shd_pkg::in_band(x1, deadzone_i));

    // rotate into the right half plane
    data_d.acc = '0;
    cx_s = (AW+1)'(v1);
    cy_s = (AW+1)'(x1);
    if (v1[AW-1]) begin
      if (!x1[AW-1]) begin
        cx_s = (AW+1)'(x1);
        cy_s = -(AW+1)'(v1);
        data_d.acc = shd_pkg::QUARTER;
      end else begin
        cx_s = -(AW+1)'(x1);
        cy_s = (AW+1)'(v1);
        data_d.acc = -shd_pkg::QUARTER;
      end
    end
    data_d.cx    = shd_pkg::VEC_W'(cx_s) <<< shd_pkg::VEC_SHIFT;
    data_d.cy    = shd_pkg::VEC_W'(cy_s) <<< shd_pkg::VEC_SHIFT;
    data_d.moved = moved;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/shd_cell.sv */
// One CORDIC vectoring micro-rotation cell with its own pipeline register.
`timescale 1ns / 1ps
module shd_cell #(
  parameter int STEP = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  shd_pkg::cordic_t data_i,
  output logic             ready_o,
  output logic             valid_o,
  output shd_pkg::cordic_t data_o,
  input  logic             ready_i
);

  logic                                valid_q;
  shd_pkg::cordic_t                    data_q, data_d;
  logic signed [shd_pkg::VEC_W-1:0]    dx, dy;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    dx = shd_pkg::shr_tz(data_i.cy, STEP);
    dy = shd_pkg::shr_tz(data_i.cx, STEP);
    data_d.moved = data_i.moved;
    if (!data_i.cy[shd_pkg::VEC_W-1]) begin
      data_d.cx  = data_i.cx + dx;
      data_d.cy  = data_i.cy - dy;
      data_d.acc = data_i.acc + shd_pkg::atan_deg(STEP);
    end else begin
      data_d.cx  = data_i.cx - dx;
      data_d.cy  = data_i.cy + dy;
      data_d.acc = data_i.acc - shd_pkg::atan_deg(STEP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/shd_round.sv */
// Output stage: offset to heading, rounding, clamping and the output register.
`timescale 1ns / 1ps
module shd_round #(
  parameter int ANGLE_FRAC_BITS = shd_pkg::ANGLE_FRAC_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  shd_pkg::cordic_t data_i,
  output logic             ready_o,
  shd_out_if.source        out_o
);

  localparam int HW = 35;
  localparam int SH = shd_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [HW-1:0] HALF_TURN = HW'(180) <<< shd_pkg::ACC_FRAC;
  localparam logic signed [HW-1:0] RND       = HW'(1) <<< (SH - 1);
  localparam logic signed [HW-1:0] LIMIT     = HW'(360) <<< ANGLE_FRAC_BITS;

  logic                          valid_q;
  logic [shd_pkg::HEAD_W-1:0]    heading_q, heading_d;
  logic                          moved_q;
  logic signed [HW-1:0]          h, hr;

  assign ready_o = !valid_q || out_o.ready;

  always_comb begin
    h = HALF_TURN + HW'(data_i.acc);
    if (h[HW-1]) begin
      h = '0;
    end
    hr = (h + RND) >>> SH;
    if (hr > LIMIT) begin
      hr = LIMIT;
    end
    heading_d = data_i.moved ? hr[shd_pkg::HEAD_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      heading_q <= heading_d;
      moved_q   <= data_i.moved;
    end
  end

  assign out_o.valid   = valid_q;
  assign out_o.heading = heading_q;
  assign out_o.moved   = moved_q;

endmodule
